// ===== rtl/core/slfd_pkg.sv =====
// ----------------------------------------------------------------------------
// slfd_pkg
// Shared types and constants for the sync/length frame deframer.
// ----------------------------------------------------------------------------
package slfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_LENGTH = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    // Position within the body: first, second, third, or beyond
    typedef enum logic [1:0] {
        POS_FUNCTION = 2'd0,
        POS_ARG_A    = 2'd1,
        POS_ARG_B    = 2'd2,
        POS_REST     = 2'd3
    } t_body_pos;

    // One finished frame
    typedef struct packed {
        logic [BYTE_W-1:0] function_code;
        logic [BYTE_W-1:0] arg_state;
        logic [BYTE_W-1:0] arg_speed;
        logic [BYTE_W-1:0] body_length;
    } t_result;

    // Parser status towards the output stage
    typedef struct packed {
        logic will_emit;   // the next transfer closes a frame
    } t_frame_status;

endpackage

// ===== rtl/core/sync_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_deframer
// Two-byte sync, length-prefixed frame deframer with a registered result.
// ----------------------------------------------------------------------------
// Received bytes enter on the rx channel at up to one transfer per clock.
// The block hunts for the header pair sync_first, sync_second, takes the
// next byte as the body length and counts that many body bytes; after the
// last body byte one result carries the function byte, the next two body
// bytes (zero where the body is shorter) and the length. A zero length
// drops the frame silently. The result of a closing byte is registered and
// sits in the output register from the next cycle. Bytes
// keep flowing while a result waits, and rx ready drops only when the next
// byte would close a frame and the output register is still occupied. The
// sync values are written through the cfg channel (index 0 first, index 1
// second); the port never stalls and unknown indexes are ignored.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slfd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [slfd_pkg::BYTE_W-1:0]      i_cfg_data,
    // received bytes
    input  logic                             i_rx_valid,
    output logic                             o_rx_ready,
    input  logic [slfd_pkg::BYTE_W-1:0]      i_rx_byte,
    // finished frames
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [slfd_pkg::BYTE_W-1:0]      o_function_code,
    output logic [slfd_pkg::BYTE_W-1:0]      o_arg_state,
    output logic [slfd_pkg::BYTE_W-1:0]      o_arg_speed,
    output logic [slfd_pkg::BYTE_W-1:0]      o_body_length
);

    logic [slfd_pkg::BYTE_W-1:0] r_sync_first;
    logic [slfd_pkg::BYTE_W-1:0] r_sync_second;
    logic                        r_res_valid;
    slfd_pkg::t_result           r_res;

    slfd_pkg::t_frame_status     fsm_status;
    slfd_pkg::t_result           fsm_result;
    logic                        rx_xfer;
    logic                        res_free;

    // Configuration registers: always ready, ignore indexes beyond the list
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= slfd_pkg::SYNC_FIRST_RESET;
            r_sync_second <= slfd_pkg::SYNC_SECOND_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == slfd_pkg::CFG_SYNC_FIRST) begin
                r_sync_first <= i_cfg_data;
            end
            if (i_cfg_index == slfd_pkg::CFG_SYNC_SECOND) begin
                r_sync_second <= i_cfg_data;
            end
        end
    end

    // The output slot is free when empty or being drained this cycle.
    // Hold rx only if the coming byte would close a frame into a full slot.
    assign res_free   = !r_res_valid || i_res_ready;
    assign o_rx_ready = res_free || !fsm_status.will_emit;
    assign rx_xfer    = i_rx_valid && o_rx_ready;

    slfd_frame_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (rx_xfer),
        .i_byte       (i_rx_byte),
        .i_sync_first (r_sync_first),
        .i_sync_second(r_sync_second),
        .o_status     (fsm_status),
        .o_result     (fsm_result)
    );

    // Result register: load on the closing byte, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (rx_xfer && fsm_status.will_emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_xfer && fsm_status.will_emit) begin
            r_res <= fsm_result;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_function_code = r_res.function_code;
    assign o_arg_state     = r_res.arg_state;
    assign o_arg_speed     = r_res.arg_speed;
    assign o_body_length   = r_res.body_length;

endmodule

// ===== rtl/core/slfd_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// slfd_frame_fsm
// Header hunt, length capture and body count for one received byte a cycle while stepped.
// ----------------------------------------------------------------------------
module slfd_frame_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [slfd_pkg::BYTE_W-1:0] i_byte,
    input  logic [slfd_pkg::BYTE_W-1:0] i_sync_first,
    input  logic [slfd_pkg::BYTE_W-1:0] i_sync_second,
    output slfd_pkg::t_frame_status     o_status,
    output slfd_pkg::t_result           o_result
);

    slfd_pkg::t_phase            r_phase,      n_phase;
    slfd_pkg::t_body_pos         r_pos,        n_pos;
    logic [slfd_pkg::BYTE_W-1:0] r_bytes_left, n_bytes_left;
    logic [slfd_pkg::BYTE_W-1:0] r_frame_len,  n_frame_len;
    logic [slfd_pkg::BYTE_W-1:0] r_function,   n_function;
    logic [slfd_pkg::BYTE_W-1:0] r_arg_a,      n_arg_a;
    logic [slfd_pkg::BYTE_W-1:0] r_arg_b,      n_arg_b;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_bytes_left = r_bytes_left;
        n_frame_len  = r_frame_len;
        n_function   = r_function;
        n_arg_a      = r_arg_a;
        n_arg_b      = r_arg_b;
        unique case (r_phase)
            slfd_pkg::PH_HUNT: begin
                if (i_byte == i_sync_first) begin
                    n_phase = slfd_pkg::PH_SECOND;
                end
            end
            slfd_pkg::PH_SECOND: begin
                // second sync value wins when both values are equal
                priority if (i_byte == i_sync_second) begin
                    n_phase = slfd_pkg::PH_LENGTH;
                end else if (i_byte == i_sync_first) begin
                    n_phase = slfd_pkg::PH_SECOND;
                end else begin
                    n_phase = slfd_pkg::PH_HUNT;
                end
            end
            slfd_pkg::PH_LENGTH: begin
                if (i_byte == '0) begin
                    n_phase = slfd_pkg::PH_HUNT;
                end else begin
                    n_phase      = slfd_pkg::PH_BODY;
                    n_frame_len  = i_byte;
                    n_bytes_left = i_byte;
                    n_pos        = slfd_pkg::POS_FUNCTION;
                    n_function   = '0;
                    n_arg_a      = '0;
                    n_arg_b      = '0;
                end
            end
            slfd_pkg::PH_BODY: begin
                unique case (r_pos)
                    slfd_pkg::POS_FUNCTION: n_function = i_byte;
                    slfd_pkg::POS_ARG_A:    n_arg_a    = i_byte;
                    slfd_pkg::POS_ARG_B:    n_arg_b    = i_byte;
                    default:                ;
                endcase
                if (r_pos != slfd_pkg::POS_REST) begin
                    n_pos = slfd_pkg::t_body_pos'(r_pos + 2'd1);
                end
                if (r_bytes_left != '0) begin
                    n_bytes_left = r_bytes_left - 8'd1;
                end
                if (r_bytes_left <= 8'd1) begin
                    n_phase = slfd_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = slfd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= slfd_pkg::PH_HUNT;
            r_pos        <= slfd_pkg::POS_FUNCTION;
            r_bytes_left <= '0;
            r_frame_len  <= '0;
            r_function   <= '0;
            r_arg_a      <= '0;
            r_arg_b      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_bytes_left <= n_bytes_left;
            r_frame_len  <= n_frame_len;
            r_function   <= n_function;
            r_arg_a      <= n_arg_a;
            r_arg_b      <= n_arg_b;
        end
    end

    // A frame closes on the last body byte, whatever its value
    assign o_status.will_emit = (r_phase == slfd_pkg::PH_BODY) && (r_bytes_left <= 8'd1);

    assign o_result.function_code = n_function;
    assign o_result.arg_state     = n_arg_a;
    assign o_result.arg_speed     = n_arg_b;
    assign o_result.body_length   = r_frame_len;

endmodule

// ===== rtl/core/slfd_checker.sv =====
// ----------------------------------------------------------------------------
// slfd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module slfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_rx_valid,
    input logic                        o_rx_ready,
    input logic                        o_res_valid,
    input logic                        i_res_ready,
    input logic [slfd_pkg::BYTE_W-1:0] o_function_code,
    input logic [slfd_pkg::BYTE_W-1:0] o_arg_state,
    input logic [slfd_pkg::BYTE_W-1:0] o_arg_speed,
    input logic [slfd_pkg::BYTE_W-1:0] o_body_length
);

    // A stalled result holds its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=>
            o_res_valid && $stable(o_function_code) && $stable(o_arg_state)
            && $stable(o_arg_speed) && $stable(o_body_length))
        else $error("result changed while stalled");

    // A new result appears only after an rx transfer
    a_res_from_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(i_rx_valid && o_rx_ready))
        else $error("result without a received byte");

    // Zero-length frames never produce a result
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_body_length != '0))
        else $error("result with zero length");

    // rx may only stall while a result is waiting
    a_rx_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_res_valid && !i_res_ready)
        else $error("rx stalled with a free result slot");

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (.*);
